[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the quality selector checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define BRBS_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// A condition that must be followed by another in the next cycle.
`define BRBS_CHECK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/brbs_pkg.sv]
// ----------------------------------------------------------------------------
// brbs_pkg
// Types and constants shared by the quality selector control and its cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package brbs_pkg;

    localparam int MAX_LEVELS = 8;
    localparam int LVL_W      = $clog2(MAX_LEVELS);
    localparam int SLOT_W     = 3;
    localparam int RATE_W     = 32;
    localparam int BOUND_W    = RATE_W + 9;

    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_BUFFER = 2'd1;
    localparam logic [1:0] KIND_LADDER = 2'd2;

    localparam logic [2:0] CFG_WEIGHT    = 3'd0;
    localparam logic [2:0] CFG_RESERVOIR = 3'd1;
    localparam logic [2:0] CFG_UPPER     = 3'd2;
    localparam logic [2:0] CFG_SLACK     = 3'd3;
    localparam logic [2:0] CFG_UPSWITCH  = 3'd4;
    localparam logic [2:0] CFG_LEVELS    = 3'd5;

    // Token that walks the row of cells during a buffer update.
    typedef struct packed {
        logic              valid;
        logic              found_inst;
        logic              found_avg;
        logic [RATE_W-1:0] lim_inst;
        logic [RATE_W-1:0] lim_avg;
        logic [RATE_W-1:0] rate_zero;
        logic [RATE_W-1:0] rate_down;
        logic [RATE_W-1:0] rate_same;
        logic [RATE_W-1:0] rate_up;
    } scan_tok_t;

    // Values held steady by the control for the length of one scan.
    typedef struct packed {
        logic [BOUND_W-1:0] bound_inst;
        logic [BOUND_W-1:0] bound_avg;
        logic [LVL_W-1:0]   top;
        logic [LVL_W-1:0]   qual;
    } scan_ctl_t;

    // Ladder write broadcast to every cell.
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        logic [RATE_W-1:0] data;
    } lad_wr_t;

endpackage

[rtl/brbs_cell.sv]
// ----------------------------------------------------------------------------
// brbs_cell
// One ladder level: holds its bit rate and updates the passing scan token.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module brbs_cell import brbs_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [LVL_W-1:0] idx,
    input  lad_wr_t          lad_wr,
    input  scan_ctl_t        scan_ctl,
    input  scan_tok_t        tok_in,
    output scan_tok_t        tok_out
);

    logic [RATE_W-1:0] ladder_reg;
    scan_tok_t         tok_reg;
    scan_tok_t         tok_next;
    logic              active;
    logic              exceed_inst;
    logic              exceed_avg;
    logic [LVL_W:0]    idx_ext;
    logic [LVL_W:0]    qual_ext;

    assign active      = idx <= scan_ctl.top;
    assign exceed_inst = BOUND_W'({ladder_reg, 8'h00}) > scan_ctl.bound_inst;
    assign exceed_avg  = BOUND_W'({ladder_reg, 8'h00}) > scan_ctl.bound_avg;
    assign idx_ext     = {1'b0, idx};
    assign qual_ext    = {1'b0, scan_ctl.qual};

    always_comb
    begin
        tok_next = tok_in;
        // The limit follows each level that does not exceed; the first one
        // that exceeds freezes it at the level below, or at level zero.
        if (active && !tok_in.found_inst)
        begin
            if (!exceed_inst || idx == '0)
            begin
                tok_next.lim_inst = ladder_reg;
            end
            tok_next.found_inst = exceed_inst;
        end
        if (active && !tok_in.found_avg)
        begin
            if (!exceed_avg || idx == '0)
            begin
                tok_next.lim_avg = ladder_reg;
            end
            tok_next.found_avg = exceed_avg;
        end
        if (idx == '0)
        begin
            tok_next.rate_zero = ladder_reg;
        end
        if (idx_ext == qual_ext)
        begin
            tok_next.rate_same = ladder_reg;
        end
        if (idx_ext + (LVL_W+1)'(1) == qual_ext)
        begin
            tok_next.rate_down = ladder_reg;
        end
        if (idx_ext == qual_ext + (LVL_W+1)'(1))
        begin
            tok_next.rate_up = ladder_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (lad_wr.en && int'(lad_wr.slot) == int'(idx))
        begin
            ladder_reg <= lad_wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

[rtl/brbs_ctrl.sv]
// ----------------------------------------------------------------------------
// brbs_ctrl
// Configuration, rate averaging, scan launch and the quality decision.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module brbs_ctrl import brbs_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        kind,
    input  logic [31:0]       throughput_bps,
    input  logic [6:0]        buffer_fill,
    input  logic [2:0]        level_slot,
    input  logic [31:0]       level_rate_bps,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [8:0]        cfg_data,
    input  scan_tok_t         tok_last,
    output scan_tok_t         tok_first,
    output scan_ctl_t         scan_ctl,
    output lad_wr_t           lad_wr,
    output logic              busy,
    output logic              done,
    output logic [2:0]        quality_index,
    output logic [31:0]       selected_rate_bps
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_AVG  = 3'b010,
        ST_SCAN = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic [8:0]         weight_reg;
    logic [6:0]         reservoir_reg;
    logic [6:0]         upper_reg;
    logic [8:0]         slack_reg;
    logic [7:0]         upsw_reg;
    logic [3:0]         levels_reg;

    logic [RATE_W-1:0]  instant_reg, instant_next;
    logic [RATE_W-1:0]  avg_reg, avg_next;
    logic [RATE_W-1:0]  sample_reg;
    logic [BOUND_W-1:0] p_old_reg;
    logic [BOUND_W-1:0] bound_inst_reg, bound_avg_reg;
    logic [6:0]         fill_reg;
    logic [LVL_W-1:0]   quality_reg, quality_next;
    logic [7:0]         run_reg, run_next;
    logic [RATE_W-1:0]  current_reg, current_next;
    logic               launch_reg;
    logic               done_reg;

    logic               accept;
    logic               decide;
    logic [8:0]         w_sat, s_sat, inv_w;
    logic [LVL_W-1:0]   top_lvl;
    logic [6:0]         fill_sat;
    logic [BOUND_W:0]   avg_acc;
    logic [7:0]         up_thr;
    logic [7:0]         run_inc;

    assign busy   = state_reg != ST_IDLE;
    assign accept = start && !busy;
    assign decide = (state_reg == ST_SCAN) && tok_last.valid;

    assign w_sat    = (weight_reg > 9'd256) ? 9'd256 : weight_reg;
    assign s_sat    = (slack_reg > 9'd256) ? 9'd256 : slack_reg;
    assign inv_w    = 9'd256 - w_sat;
    assign fill_sat = (buffer_fill > 7'd100) ? 7'd100 : buffer_fill;
    assign up_thr   = (upsw_reg == 8'd0) ? 8'd1 : upsw_reg;
    assign run_inc  = (run_reg == 8'hFF) ? run_reg : run_reg + 8'd1;
    assign avg_acc  = (BOUND_W+1)'(p_old_reg)
                    + (BOUND_W+1)'(BOUND_W'(inv_w) * BOUND_W'(sample_reg));

    always_comb
    begin
        if (levels_reg == 4'd0)
        begin
            top_lvl = '0;
        end
        else if (int'(levels_reg) > MAX_LEVELS)
        begin
            top_lvl = LVL_W'(MAX_LEVELS - 1);
        end
        else
        begin
            top_lvl = LVL_W'(levels_reg - 4'd1);
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        instant_next = instant_reg;
        avg_next     = avg_reg;
        quality_next = quality_reg;
        run_next     = run_reg;
        current_next = current_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && kind == KIND_SAMPLE)
                begin
                    instant_next = throughput_bps;
                    if (avg_reg == '0)
                    begin
                        avg_next = throughput_bps;
                    end
                    else
                    begin
                        state_next = ST_AVG;
                    end
                end
                else if (accept && kind == KIND_BUFFER)
                begin
                    state_next = ST_SCAN;
                    if (quality_reg > top_lvl)
                    begin
                        quality_next = top_lvl;
                    end
                end
            end
            ST_AVG:
            begin
                avg_next   = avg_acc[RATE_W+7:8];
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (decide)
                begin
                    state_next = ST_IDLE;
                    if (fill_reg < reservoir_reg)
                    begin
                        run_next     = '0;
                        quality_next = '0;
                        current_next = tok_last.rate_zero;
                    end
                    else if (fill_reg < upper_reg)
                    begin
                        run_next     = '0;
                        current_next = tok_last.rate_same;
                        if (current_reg > tok_last.lim_inst)
                        begin
                            if (quality_reg != '0)
                            begin
                                quality_next = quality_reg - LVL_W'(1);
                                current_next = tok_last.rate_down;
                            end
                        end
                        else if (current_reg < tok_last.lim_inst)
                        begin
                            if (quality_reg < scan_ctl.top)
                            begin
                                quality_next = quality_reg + LVL_W'(1);
                                current_next = tok_last.rate_up;
                            end
                        end
                    end
                    else
                    begin
                        current_next = tok_last.rate_same;
                        if (current_reg < tok_last.lim_avg)
                        begin
                            run_next = run_inc;
                            if (run_inc >= up_thr && quality_reg < scan_ctl.top)
                            begin
                                run_next     = '0;
                                quality_next = quality_reg + LVL_W'(1);
                                current_next = tok_last.rate_up;
                            end
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            weight_reg    <= 9'd205;
            reservoir_reg <= 7'd25;
            upper_reg     <= 7'd100;
            slack_reg     <= 9'd205;
            upsw_reg      <= 8'd15;
            levels_reg    <= 4'd1;
            instant_reg   <= '0;
            avg_reg       <= '0;
            quality_reg   <= '0;
            run_reg       <= '0;
            current_reg   <= '0;
            launch_reg    <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            instant_reg <= instant_next;
            avg_reg     <= avg_next;
            quality_reg <= quality_next;
            run_reg     <= run_next;
            current_reg <= current_next;
            launch_reg  <= accept && kind == KIND_BUFFER;
            done_reg    <= decide;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_WEIGHT:    weight_reg    <= cfg_data;
                    CFG_RESERVOIR: reservoir_reg <= cfg_data[6:0];
                    CFG_UPPER:     upper_reg     <= cfg_data[6:0];
                    CFG_SLACK:     slack_reg     <= cfg_data;
                    CFG_UPSWITCH:  upsw_reg      <= cfg_data[7:0];
                    CFG_LEVELS:    levels_reg    <= cfg_data[3:0];
                    default:       ;
                endcase
            end
        end
    end

    // Operand and bound registers; they carry no control meaning.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg     <= throughput_bps;
            p_old_reg      <= BOUND_W'(w_sat) * BOUND_W'(avg_reg);
            bound_inst_reg <= BOUND_W'(s_sat) * BOUND_W'(instant_reg);
            bound_avg_reg  <= BOUND_W'(s_sat) * BOUND_W'(avg_reg);
            fill_reg       <= fill_sat;
        end
    end

    always_comb
    begin
        tok_first       = '0;
        tok_first.valid = launch_reg;
    end

    assign scan_ctl.bound_inst = bound_inst_reg;
    assign scan_ctl.bound_avg  = bound_avg_reg;
    assign scan_ctl.top        = top_lvl;
    assign scan_ctl.qual       = quality_reg;

    assign lad_wr.en   = accept && kind == KIND_LADDER && int'(level_slot) < MAX_LEVELS;
    assign lad_wr.slot = level_slot;
    assign lad_wr.data = level_rate_bps;

    assign done              = done_reg;
    assign quality_index     = 3'(quality_reg);
    assign selected_rate_bps = current_reg;

endmodule

[rtl/buffer_rate_bitrate_selector_top.sv]
// ----------------------------------------------------------------------------
// buffer_rate_bitrate_selector_top
// Hybrid buffer- and throughput-based quality level selector for streaming.
// ----------------------------------------------------------------------------
// An item is transferred on a clock edge where start is high and busy is low.
// A throughput sample that seeds the average and a ladder write leave busy
// low; any other sample keeps busy high while the average is updated. For a
// buffer update the slack-weighted bounds are registered at the transfer
// itself, then the scan token walks the row of ladder cells, registered in
// each, the control decides on the token that leaves the last cell, and the
// result is registered and shown. The result is shown for a single cycle
// with done high, and busy is already low in that cycle, so the next item may
// be transferred at its end. The receiver cannot stall the block: a result
// that is not taken in its done cycle is lost.
// ----------------------------------------------------------------------------
// Each cell holds the bit rate of one quality level. During a buffer update a
// token passes from cell to cell once per cycle; every cell compares its rate
// against both bounds, updates the running limits for the instant and the
// averaged rate, and copies its rate into the token at level zero, at the
// current quality and its neighbours. The control then applies the reservoir,
// cushion and cautious upswitch rules on the token that leaves the last cell.
// Configuration writes are taken at any edge with cfg_we high and should only
// be made while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module buffer_rate_bitrate_selector_top import brbs_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [1:0]  kind,
    input  logic [31:0] throughput_bps,
    input  logic [6:0]  buffer_fill,
    input  logic [2:0]  level_slot,
    input  logic [31:0] level_rate_bps,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [8:0]  cfg_data,
    output logic        busy,
    output logic        done,
    output logic [2:0]  quality_index,
    output logic [31:0] selected_rate_bps
);

    // Token links between the control and the cells; link i feeds cell i.
    scan_tok_t tok_link [MAX_LEVELS+1];
    scan_ctl_t scan_ctl;
    lad_wr_t   lad_wr;

    brbs_ctrl u_ctrl (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .kind              (kind),
        .throughput_bps    (throughput_bps),
        .buffer_fill       (buffer_fill),
        .level_slot        (level_slot),
        .level_rate_bps    (level_rate_bps),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .tok_last          (tok_link[MAX_LEVELS]),
        .tok_first         (tok_link[0]),
        .scan_ctl          (scan_ctl),
        .lad_wr            (lad_wr),
        .busy              (busy),
        .done              (done),
        .quality_index     (quality_index),
        .selected_rate_bps (selected_rate_bps)
    );

    // The row of ladder cells, one per quality level.
    for (genvar i = 0; i < MAX_LEVELS; i++)
    begin : g_cell
        brbs_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .idx      (LVL_W'(i)),
            .lad_wr   (lad_wr),
            .scan_ctl (scan_ctl),
            .tok_in   (tok_link[i]),
            .tok_out  (tok_link[i+1])
        );
    end

endmodule

[rtl/brbs_checker.sv]
// ----------------------------------------------------------------------------
// brbs_checker
// Port-level checks on the transfer and result timing of the selector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module brbs_checker import brbs_pkg::*; (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic [1:0] kind,
    input logic       busy,
    input logic       done
);

    // A result only appears once the block has gone idle again.
    `BRBS_CHECK(a_done_idle, done |-> !busy, "result shown while busy")
    // A buffer update keeps the block busy in the following cycle.
    `BRBS_CHECK_NEXT(a_buf_busy, start && !busy && kind == KIND_BUFFER, busy, "no scan")
    // Results are single-cycle strobes.
    `BRBS_CHECK_NEXT(a_done_pulse, done, !done, "result strobe held")
    // A ladder write finishes at once and causes no result.
    `BRBS_CHECK_NEXT(a_lad_quick, start && !busy && kind == KIND_LADDER, !busy && !done, "ladder")

endmodule

bind buffer_rate_bitrate_selector_top brbs_checker u_brbs_checker (.*);

[tb/buffer_rate_bitrate_selector_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buffer_rate_bitrate_selector_top_tb
// Self-checking bench for the buffer- and throughput-based quality selector.
// A short table of directed items is followed by phases of random traffic,
// each phase under a fresh register setting. Every buffer update is predicted
// by a behavioural copy of the selector kept inside this bench, and each
// result strobe is compared with the oldest outstanding prediction.
// ----------------------------------------------------------------------------

module buffer_rate_bitrate_selector_top_tb;

    import brbs_pkg::*;

    // Kind code that the block must ignore.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // Register indexes past the last register; writes to them do nothing.
    localparam logic [2:0] CFG_SPARE_LO = 3'd6;
    localparam logic [2:0] CFG_SPARE_HI = 3'd7;

    // Settling margin; it is longer than a buffer update.
    localparam int SETTLE_CYCLES = 12;
    localparam int MAX_GAP       = 12;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 175;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] tput;
        logic [6:0]  fill;
        logic [2:0]  slot;
        logic [31:0] rate;
    } stim_t;

    typedef struct packed {
        logic [2:0]  quality;
        logic [31:0] rate_bps;
    } selection_t;

    typedef enum logic { ROW_ITEM, ROW_REG } row_kind_t;

    // One line of the directed table: either an item or a register write.
    // Where typed is set, the result is written into the table by hand.
    typedef struct packed {
        row_kind_t  what;
        stim_t      it;
        logic [2:0] reg_idx;
        logic [8:0] reg_val;
        logic       typed;
        selection_t want;
    } plan_row_t;

    // ------------------------------------------------------------------------
    // Block ports
    // ------------------------------------------------------------------------
    logic        clk;
    logic        rst_n;
    logic        start;
    logic [1:0]  kind;
    logic [31:0] throughput_bps;
    logic [6:0]  buffer_fill;
    logic [2:0]  level_slot;
    logic [31:0] level_rate_bps;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [8:0]  cfg_data;
    logic        busy;
    logic        done;
    logic [2:0]  quality_index;
    logic [31:0] selected_rate_bps;

    buffer_rate_bitrate_selector_top dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .kind              (kind),
        .throughput_bps    (throughput_bps),
        .buffer_fill       (buffer_fill),
        .level_slot        (level_slot),
        .level_rate_bps    (level_rate_bps),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .busy              (busy),
        .done              (done),
        .quality_index     (quality_index),
        .selected_rate_bps (selected_rate_bps)
    );

    // ------------------------------------------------------------------------
    // Behavioural copy of the selector: registers and state.
    // ------------------------------------------------------------------------
    logic [8:0]  reg_weight;
    logic [6:0]  reg_reservoir;
    logic [6:0]  reg_upper;
    logic [8:0]  reg_slack;
    logic [7:0]  reg_upswitch;
    logic [3:0]  reg_levels;

    logic [31:0] sel_ladder [MAX_LEVELS];
    logic [31:0] sel_inst_bps;
    logic [31:0] sel_avg_bps;
    logic [31:0] sel_cur_bps;
    logic [2:0]  sel_quality;
    logic [7:0]  sel_run;

    // Predicted results, oldest first.
    selection_t  pending_selections [$];

    int unsigned items_sent;
    int unsigned results_seen;
    int unsigned reg_writes;
    int unsigned fail_count;
    int unsigned burst_left;
    int          fill_walk;

    // ------------------------------------------------------------------------
    // Clock: 4 ns period.
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // A hard stop in case the block stops answering.
    initial
    begin
        #2000000;
        $display("buffer_rate_bitrate_selector_top test failed");
        $finish;
    end

    // Counts a failure and prints the first few of them.
    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("ERROR at %0t ns: %s", $realtime, msg);
    endfunction

    // Resets the behavioural copy to the state the block leaves reset in.
    function automatic void reset_model();
        reg_weight    = 9'd205;
        reg_reservoir = 7'd25;
        reg_upper     = 7'd100;
        reg_slack     = 9'd205;
        reg_upswitch  = 8'd15;
        reg_levels    = 4'd1;
        for (int i = 0; i < MAX_LEVELS; i++)
            sel_ladder[i] = '0;
        sel_inst_bps = '0;
        sel_avg_bps  = '0;
        sel_cur_bps  = '0;
        sel_quality  = '0;
        sel_run      = '0;
    endfunction

    // Mirrors one register write; each register keeps only its own width.
    function automatic void model_register(input logic [2:0] idx, input logic [8:0] val);
        case (idx)
            CFG_WEIGHT:    reg_weight    = val;
            CFG_RESERVOIR: reg_reservoir = val[6:0];
            CFG_UPPER:     reg_upper     = val[6:0];
            CFG_SLACK:     reg_slack     = val;
            CFG_UPSWITCH:  reg_upswitch  = val[7:0];
            CFG_LEVELS:    reg_levels    = val[3:0];
            default: ;
        endcase
    endfunction

    // Level below the first one whose rate times 256 exceeds slack times the
    // measured rate, floored at zero; the top level when none does.
    function automatic int unsigned rate_limit(input logic [31:0] measured,
                                               input int unsigned n);
        logic [63:0] bound;
        logic [63:0] scaled;
        logic [8:0]  slack;
        slack = (reg_slack > 9'd256) ? 9'd256 : reg_slack;
        bound = 64'(slack) * 64'(measured);
        for (int unsigned i = 0; i < n; i++)
        begin
            scaled = {24'd0, sel_ladder[i], 8'd0};
            if (scaled > bound)
                return (i == 0) ? 0 : i - 1;
        end
        return n - 1;
    endfunction

    // Applies one transferred item to the behavioural copy. A buffer update
    // yields the selection that the block must report for it.
    function automatic void advance_model(input stim_t it, output logic produced,
                                          output selection_t sel);
        logic [63:0] acc;
        logic [8:0]  weight;
        logic [31:0] lim_inst;
        logic [31:0] lim_avg;
        logic [6:0]  fill;
        int unsigned n;
        int unsigned top;
        produced = 1'b0;
        sel      = '0;
        case (it.kind)
            KIND_SAMPLE:
            begin
                sel_inst_bps = it.tput;
                if (sel_avg_bps == 0)
                    sel_avg_bps = it.tput;
                else
                begin
                    weight      = (reg_weight > 9'd256) ? 9'd256 : reg_weight;
                    acc         = 64'(weight) * 64'(sel_avg_bps)
                                + 64'(9'd256 - weight) * 64'(it.tput);
                    sel_avg_bps = acc[39:8];
                end
            end
            KIND_LADDER:
                sel_ladder[it.slot] = it.rate;
            KIND_BUFFER:
            begin
                n    = (reg_levels == 0) ? 1 : ((reg_levels > MAX_LEVELS) ? MAX_LEVELS
                                                                          : reg_levels);
                top  = n - 1;
                fill = (it.fill > 7'd100) ? 7'd100 : it.fill;
                if (sel_quality > top)
                    sel_quality = top[2:0];
                lim_inst = sel_ladder[rate_limit(sel_inst_bps, n)];
                lim_avg  = sel_ladder[rate_limit(sel_avg_bps, n)];
                if (fill < reg_reservoir)
                begin
                    // Buffer nearly empty: drop to the lowest level at once.
                    sel_run     = '0;
                    sel_quality = '0;
                end
                else if (fill < reg_upper)
                begin
                    // Cushion: one step towards the instant-rate limit.
                    sel_run = '0;
                    if (sel_cur_bps > lim_inst)
                    begin
                        if (sel_quality > 0)
                            sel_quality--;
                    end
                    else if (sel_cur_bps < lim_inst)
                    begin
                        if (sel_quality < top)
                            sel_quality++;
                    end
                end
                else if (sel_cur_bps < lim_avg)
                begin
                    // Buffer full: step up only after a long enough run.
                    if (sel_run < 8'd255)
                        sel_run++;
                    if (sel_run >= reg_upswitch && sel_quality < top)
                    begin
                        sel_run = '0;
                        sel_quality++;
                    end
                end
                sel_cur_bps  = sel_ladder[sel_quality];
                produced     = 1'b1;
                sel.quality  = sel_quality;
                sel.rate_bps = sel_cur_bps;
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Directed table helpers.
    // ------------------------------------------------------------------------
    function automatic plan_row_t row_item(input logic [1:0] k, input logic [31:0] tput,
                                           input logic [6:0] fill, input logic [2:0] slot,
                                           input logic [31:0] rate);
        plan_row_t r;
        r         = '0;
        r.what    = ROW_ITEM;
        r.it.kind = k;
        r.it.tput = tput;
        r.it.fill = fill;
        r.it.slot = slot;
        r.it.rate = rate;
        return r;
    endfunction

    function automatic plan_row_t row_check(input logic [6:0] fill, input logic [2:0] q,
                                            input logic [31:0] rate);
        plan_row_t r;
        r               = row_item(KIND_BUFFER, 32'd0, fill, 3'd0, 32'd0);
        r.typed         = 1'b1;
        r.want.quality  = q;
        r.want.rate_bps = rate;
        return r;
    endfunction

    function automatic plan_row_t row_reg(input logic [2:0] idx, input logic [8:0] val);
        plan_row_t r;
        r         = '0;
        r.what    = ROW_REG;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    // Idle cycles before the next item: mostly random, with stretches of
    // back-to-back transfers mixed in.
    function automatic int unsigned draw_gap();
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 99) < 4)
        begin
            burst_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, MAX_GAP);
    endfunction

    // ------------------------------------------------------------------------
    // Driver tasks. Each is entered just after a rising edge and returns just
    // after one, so every input gets at most one assignment per edge.
    // ------------------------------------------------------------------------

    // Presents one item, holds it until the block takes the transfer and
    // records the expected result. When typed is set the hand-written
    // result replaces the predicted one.
    task automatic send_item(input stim_t it, input logic typed, input selection_t want);
        logic       produced;
        selection_t sel;
        int unsigned gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start          <= 1'b1;
        kind           <= it.kind;
        throughput_bps <= it.tput;
        buffer_fill    <= it.fill;
        level_slot     <= it.slot;
        level_rate_bps <= it.rate;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // The transfer happened at this edge.
        items_sent++;
        advance_model(it, produced, sel);
        if (produced)
            pending_selections.push_back(typed ? want : sel);
    endtask

    // Stops issuing items, lets every outstanding result arrive, then allows
    // for a sample or ladder write that may still be in progress.
    task automatic drain_block();
        start <= 1'b0;
        @(posedge clk);
        while (pending_selections.size() != 0 || busy)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write; the block must be idle.
    task automatic write_register(input logic [2:0] idx, input logic [8:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        model_register(idx, val);
        reg_writes++;
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Draws a random item. Most traffic is meaningful: samples around the
    // ladder rates and a buffer fill that wanders so that all three regions
    // are visited, with runs at the top. The rest is noise.
    task automatic draw_item(output stim_t it);
        int unsigned pick;
        int unsigned j;
        logic [63:0] scaled;
        // Fields that the kind does not use still carry random values.
        it.kind = 2'($urandom_range(0, 3));
        it.tput = $urandom;
        it.fill = 7'($urandom_range(0, 127));
        it.slot = 3'($urandom_range(0, 7));
        it.rate = $urandom;
        pick    = $urandom_range(0, 99);
        if (pick < 35)
        begin
            it.kind = KIND_SAMPLE;
            j       = $urandom_range(0, 99);
            if (j < 70)
            begin
                scaled  = 64'(sel_ladder[$urandom_range(0, MAX_LEVELS - 1)])
                        * 64'($urandom_range(100, 600));
                scaled  = scaled >> 8;
                it.tput = (scaled > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : scaled[31:0];
            end
            else if (j < 80)
                it.tput = 32'd0;
            else if (j < 90)
                it.tput = $urandom_range(0, 1000);
        end
        else if (pick < 85)
        begin
            it.kind = KIND_BUFFER;
            j       = $urandom_range(0, 99);
            if (j < 8)
                fill_walk = $urandom_range(0, 127);
            else if (j < 30)
                fill_walk = 100;
            else
                fill_walk = fill_walk + int'($urandom_range(0, 24)) - 12;
            if (fill_walk < 0)
                fill_walk = 0;
            if (fill_walk > 127)
                fill_walk = 127;
            it.fill = fill_walk[6:0];
        end
        else if (pick < 96)
        begin
            it.kind = KIND_LADDER;
            if ($urandom_range(0, 99) < 80)
                it.rate = (32'(it.slot) + 32'd1) * $urandom_range(100000, 1000000);
        end
        else
            it.kind = KIND_UNUSED;
    endtask

    // ------------------------------------------------------------------------
    // Result monitor: sampled at the rising edge that ends the done cycle.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : check_result
        selection_t want;
        if (rst_n && done)
        begin
            results_seen++;
            if (pending_selections.size() == 0)
                note_failure($sformatf("result q=%0d rate=%0d with nothing expected",
                                       quality_index, selected_rate_bps));
            else
            begin
                want = pending_selections.pop_front();
                if (quality_index !== want.quality || selected_rate_bps !== want.rate_bps)
                    note_failure($sformatf("expected q=%0d rate=%0d, got q=%0d rate=%0d",
                                           want.quality, want.rate_bps,
                                           quality_index, selected_rate_bps));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin : main_sequence
        plan_row_t  plan [$];
        stim_t      it;
        selection_t none;
        logic [6:0] res_lo;
        int         left;

        rst_n          <= 1'b0;
        start          <= 1'b0;
        kind           <= KIND_SAMPLE;
        throughput_bps <= '0;
        buffer_fill    <= '0;
        level_slot     <= '0;
        level_rate_bps <= '0;
        cfg_we         <= 1'b0;
        cfg_index      <= CFG_WEIGHT;
        cfg_data       <= '0;
        items_sent     = 0;
        results_seen   = 0;
        reg_writes     = 0;
        fail_count     = 0;
        burst_left     = 0;
        fill_walk      = 50;
        none           = '0;
        reset_model();

        // Reset is applied once, at the start.
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --------------------------------------------------------------------
        // Directed table. The whole ladder is loaded first, so that no buffer
        // update ever reads a level that has never been written.
        // --------------------------------------------------------------------
        plan.push_back(row_item(KIND_LADDER, 32'd0, 7'd0, 3'd0, 32'd100000));
        plan.push_back(row_item(KIND_LADDER, 32'd0, 7'd0, 3'd1, 32'd250000));
        plan.push_back(row_item(KIND_LADDER, 32'd0, 7'd0, 3'd2, 32'd500000));
        plan.push_back(row_item(KIND_LADDER, 32'd0, 7'd0, 3'd3, 32'd1000000));
        plan.push_back(row_item(KIND_LADDER, 32'd0, 7'd0, 3'd4, 32'd2000000));
        plan.push_back(row_item(KIND_LADDER, 32'd0, 7'd0, 3'd5, 32'd4000000));
        plan.push_back(row_item(KIND_LADDER, 32'd0, 7'd0, 3'd6, 32'd8000000));
        plan.push_back(row_item(KIND_LADDER, 32'd0, 7'd0, 3'd7, 32'hFFFF_FFFF));
        // Right after reset with a single level: always level zero.
        plan.push_back(row_check(7'd0, 3'd0, 32'd100000));
        // A fill past 100 saturates; one level still leaves only level zero.
        plan.push_back(row_check(7'd127, 3'd0, 32'd100000));
        // An unknown kind is swallowed without a result.
        plan.push_back(row_item(KIND_UNUSED, 32'hFFFF_FFFF, 7'd127, 3'd7, 32'hFFFF_FFFF));
        // A zero sample leaves the average empty, the next one seeds it.
        plan.push_back(row_item(KIND_SAMPLE, 32'd0, 7'd0, 3'd0, 32'd0));
        plan.push_back(row_item(KIND_SAMPLE, 32'hFFFF_FFFF, 7'd0, 3'd0, 32'd0));
        plan.push_back(row_reg(CFG_LEVELS, 9'd8));
        plan.push_back(row_item(KIND_BUFFER, 32'd0, 7'd60, 3'd0, 32'd0));
        plan.push_back(row_item(KIND_BUFFER, 32'd0, 7'd100, 3'd0, 32'd0));
        // An upswitch run of zero behaves as a run of one.
        plan.push_back(row_reg(CFG_UPSWITCH, 9'd0));
        plan.push_back(row_item(KIND_BUFFER, 32'd0, 7'd100, 3'd0, 32'd0));
        plan.push_back(row_item(KIND_SAMPLE, 32'd1500000, 7'd0, 3'd0, 32'd0));
        // Shrinking the ladder clamps the current quality to the new top.
        plan.push_back(row_reg(CFG_LEVELS, 9'd2));
        plan.push_back(row_check(7'd24, 3'd0, 32'd100000));
        plan.push_back(row_item(KIND_BUFFER, 32'd0, 7'd25, 3'd0, 32'd0));
        // A level count past the maximum saturates; spare indexes are inert.
        plan.push_back(row_reg(CFG_LEVELS, 9'd15));
        plan.push_back(row_reg(CFG_SPARE_LO, 9'h1FF));
        plan.push_back(row_reg(CFG_SPARE_HI, 9'h1FF));
        plan.push_back(row_item(KIND_BUFFER, 32'd0, 7'd80, 3'd0, 32'd0));

        foreach (plan[i])
        begin
            if (plan[i].what == ROW_REG)
            begin
                drain_block();
                write_register(plan[i].reg_idx, plan[i].reg_val);
            end
            else
                send_item(plan[i].it, plan[i].typed, plan[i].want);
        end

        // --------------------------------------------------------------------
        // Random phases. The first two use the low and the high extremes of
        // every register; the rest draw settings at random, sometimes with
        // values past the legal range.
        // --------------------------------------------------------------------
        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain_block();
            if (phase == 0)
            begin
                write_register(CFG_WEIGHT, 9'd0);
                write_register(CFG_RESERVOIR, 9'd0);
                write_register(CFG_UPPER, 9'd0);
                write_register(CFG_SLACK, 9'd0);
                write_register(CFG_UPSWITCH, 9'd1);
                write_register(CFG_LEVELS, 9'd1);
            end
            else if (phase == 1)
            begin
                write_register(CFG_WEIGHT, 9'd256);
                write_register(CFG_RESERVOIR, 9'd100);
                write_register(CFG_UPPER, 9'd100);
                write_register(CFG_SLACK, 9'd256);
                write_register(CFG_UPSWITCH, 9'd255);
                write_register(CFG_LEVELS, 9'd8);
            end
            else
            begin
                res_lo = 7'($urandom_range(0, 50));
                write_register(CFG_WEIGHT, 9'($urandom_range(0, 511)));
                if ($urandom_range(0, 3) == 0)
                begin
                    write_register(CFG_RESERVOIR, 9'($urandom_range(0, 511)));
                    write_register(CFG_UPPER, 9'($urandom_range(0, 511)));
                end
                else
                begin
                    write_register(CFG_RESERVOIR, 9'(res_lo));
                    write_register(CFG_UPPER, 9'($urandom_range(res_lo, 105)));
                end
                if ($urandom_range(0, 1) == 0)
                    write_register(CFG_SLACK, 9'($urandom_range(0, 511)));
                else
                    write_register(CFG_SLACK, 9'($urandom_range(150, 256)));
                if ($urandom_range(0, 3) == 0)
                    write_register(CFG_UPSWITCH, 9'($urandom_range(0, 511)));
                else
                    write_register(CFG_UPSWITCH, 9'($urandom_range(0, 20)));
                write_register(CFG_LEVELS, 9'($urandom_range(0, 15)));
            end

            // A fresh ladder at the start of each phase, scaled up with the slot.
            left = PHASE_ITEMS;
            for (int s = 0; s < MAX_LEVELS; s++)
            begin
                it.kind = KIND_LADDER;
                it.tput = $urandom;
                it.fill = 7'($urandom_range(0, 127));
                it.slot = 3'(s);
                it.rate = (s == MAX_LEVELS - 1 && $urandom_range(0, 3) == 0)
                        ? 32'hFFFF_FFFF
                        : (32'(s) + 32'd1) * $urandom_range(100000, 1000000);
                send_item(it, 1'b0, none);
                left--;
            end
            while (left > 0)
            begin
                draw_item(it);
                send_item(it, 1'b0, none);
                if (it.kind != KIND_UNUSED)
                    left--;
            end
        end

        // --------------------------------------------------------------------
        // Wind down: wait for outstanding results, then for a settling margin so
        // that a stray strobe would still be caught.
        // --------------------------------------------------------------------
        start <= 1'b0;
        for (int w = 0; w < 4000 && pending_selections.size() != 0; w++)
            @(posedge clk);
        repeat (SETTLE_CYCLES + 8) @(posedge clk);
        if (pending_selections.size() != 0)
            note_failure($sformatf("%0d expected results never arrived",
                                   pending_selections.size()));

        $display("Run covered %0d item transfers and %0d selections in %0d register phases.",
                 items_sent, results_seen, PHASES);
        $display("Register writes: %0d, failures: %0d.", reg_writes, fail_count);
        if (fail_count == 0)
            $display("buffer_rate_bitrate_selector_top test passed");
        else
            $display("buffer_rate_bitrate_selector_top test failed");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/brbs_pkg.sv
rtl/brbs_cell.sv
rtl/brbs_ctrl.sv
rtl/buffer_rate_bitrate_selector_top.sv
rtl/brbs_checker.sv
tb/buffer_rate_bitrate_selector_top_tb.sv
